// ===== rtl/fca_pkg.sv =====
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants for the FAT chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_W  = 14;

  localparam logic [DATA_W-1:0] END_MARK  = 16'hFFFF;
  localparam logic [DATA_W-1:0] FREE_MARK = 16'h0000;
  localparam logic [CFG_W-1:0]  CFG_RESET = 14'd8192;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_FREE  = 3'd2,
    OP_ALLOC = 3'd3,
    OP_COUNT = 3'd4
  } fca_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } fca_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_FREE_CHK,
    S_ALLOC_SCAN,
    S_ALLOC_LINK,
    S_COUNT_SCAN,
    S_DONE
  } fca_state_t;

  typedef struct packed {
    fca_status_t       status;
    logic [DATA_W-1:0] value;
  } fca_res_t;

endpackage

// ===== rtl/fca_table_ram.sv =====
// ----------------------------------------------------------------------------
// fca_table_ram
// Link table storage: one write port, one registered read port, write-first
// on a same-address collision.
// ----------------------------------------------------------------------------
module fca_table_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // forward the word being written so a read of the same entry sees it
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fca_ctrl.sv =====
// ----------------------------------------------------------------------------
// fca_ctrl
// Request sequencer: decodes a request, walks the table through the RAM one
// entry per cycle and holds the result until the output stage takes it.
// ----------------------------------------------------------------------------
module fca_ctrl #(
  parameter int TABLE_ENTRIES = 8192,
  parameter int IW            = 13
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_operation,
  input  logic [fca_pkg::DATA_W-1:0] in_index,
  input  logic [fca_pkg::DATA_W-1:0] in_link_value,
  input  logic [fca_pkg::DATA_W-1:0] lim,
  output logic                     res_valid,
  output fca_pkg::fca_res_t        res,
  input  logic                     res_ready,
  output logic                     ram_we,
  output logic [IW-1:0]            ram_waddr,
  output logic [fca_pkg::DATA_W-1:0] ram_wdata,
  output logic [IW-1:0]            ram_raddr,
  input  logic [fca_pkg::DATA_W-1:0] ram_rdata
);

  import fca_pkg::*;

  localparam logic [DATA_W-1:0] TE = DATA_W'(TABLE_ENTRIES);

  fca_state_t        state_r, state_nxt;
  logic [DATA_W-1:0] idx_r, idx_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [DATA_W-1:0] ptr_r, ptr_nxt;
  logic [DATA_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0] lim_r, lim_nxt;
  fca_status_t       st_r, st_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  logic accept;
  logic in_rng, in_end, lim_zero;
  logic rd_zero, rd_end, rd_rng, scan_last, link_needed;
  logic [DATA_W-1:0] cnt_inc;

  assign accept      = in_valid && (state_r == S_IDLE);
  assign in_rng      = in_index < TE;
  assign in_end      = in_index == END_MARK;
  assign lim_zero    = lim == '0;
  assign rd_zero     = ram_rdata == FREE_MARK;
  assign rd_end      = ram_rdata == END_MARK;
  assign rd_rng      = ram_rdata < TE;
  assign scan_last   = ptr_r >= lim_r;
  assign link_needed = (idx_r != END_MARK) && (idx_r != DATA_W'(cur_r));
  assign cnt_inc     = cnt_r + DATA_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            OP_READ:  state_nxt = in_rng ? S_RD_WAIT : S_DONE;
            OP_FREE:  state_nxt = (!in_end && in_rng) ? S_FREE_CHK : S_DONE;
            OP_ALLOC: state_nxt = ((!in_end && !in_rng) || lim_zero) ? S_DONE
                                                                      : S_ALLOC_SCAN;
            OP_COUNT: state_nxt = lim_zero ? S_DONE : S_COUNT_SCAN;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_RD_WAIT: state_nxt = S_DONE;
      S_FREE_CHK: begin
        if (rd_zero || rd_end || !rd_rng) begin
          state_nxt = S_DONE;
        end
      end
      S_ALLOC_SCAN: begin
        if (rd_zero) begin
          state_nxt = link_needed ? S_ALLOC_LINK : S_DONE;
        end else if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_ALLOC_LINK: state_nxt = S_DONE;
      S_COUNT_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    lim_nxt   = lim_r;
    st_nxt    = st_r;
    val_nxt   = val_r;
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = FREE_MARK;
    ram_raddr = '0;
    in_stall  = state_r != S_IDLE;
    res_valid = state_r == S_DONE;
    res       = '{status: st_r, value: val_r};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = in_index;
          cur_nxt = '0;
          ptr_nxt = DATA_W'(1);
          cnt_nxt = '0;
          lim_nxt = lim;
          st_nxt  = ST_OK;
          val_nxt = '0;
          unique case (in_operation)
            OP_WRITE: begin
              if (in_rng) begin
                ram_we    = 1'b1;
                ram_waddr = in_index[IW-1:0];
                ram_wdata = in_link_value;
              end else begin
                st_nxt = ST_RANGE;
              end
            end
            OP_READ: begin
              if (in_rng) begin
                ram_raddr = in_index[IW-1:0];
              end else begin
                st_nxt = ST_RANGE;
              end
            end
            OP_FREE: begin
              if (!in_end && !in_rng) begin
                st_nxt = ST_RANGE;
              end
              ram_raddr = in_index[IW-1:0];
              cur_nxt   = in_index[IW-1:0];
            end
            OP_ALLOC: begin
              if (!in_end && !in_rng) begin
                st_nxt = ST_RANGE;
              end else if (lim_zero) begin
                st_nxt = ST_NO_FREE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: val_nxt = ram_rdata;
      S_FREE_CHK: begin
        if (rd_zero) begin
          val_nxt = cnt_r;
        end else begin
          // clear this entry and follow its link
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = FREE_MARK;
          cnt_nxt   = cnt_inc;
          val_nxt   = cnt_inc;
          ram_raddr = ram_rdata[IW-1:0];
          cur_nxt   = ram_rdata[IW-1:0];
          if (!rd_end && !rd_rng) begin
            st_nxt = ST_RANGE;
          end
        end
      end
      S_ALLOC_SCAN: begin
        if (rd_zero) begin
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = END_MARK;
          val_nxt   = DATA_W'(cur_r);
        end else if (scan_last) begin
          st_nxt = ST_NO_FREE;
        end else begin
          ram_raddr = ptr_r[IW-1:0];
          cur_nxt   = ptr_r[IW-1:0];
          ptr_nxt   = ptr_r + DATA_W'(1);
        end
      end
      S_ALLOC_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IW-1:0];
        ram_wdata = DATA_W'(cur_r);
      end
      S_COUNT_SCAN: begin
        cnt_nxt = rd_zero ? cnt_inc : cnt_r;
        if (scan_last) begin
          val_nxt = cnt_nxt;
        end else begin
          ram_raddr = ptr_r[IW-1:0];
          cur_nxt   = ptr_r[IW-1:0];
          ptr_nxt   = ptr_r + DATA_W'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cur_r <= cur_nxt;
    ptr_r <= ptr_nxt;
    cnt_r <= cnt_nxt;
    lim_r <= lim_nxt;
    st_r  <= st_nxt;
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/fat_chain_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fat_chain_allocator_unit
// FAT16-style link table with write, read, chain free, allocate and free count.
// ----------------------------------------------------------------------------
// One request is processed at a time; a finished result waits in the output
// register while the next request is taken. Write entry, range errors, unused
// codes and an empty search limit go straight to the result; read entry waits
// for the RAM read; free chain visits each chain entry; count free scans the
// whole limit; allocate scans to the first free entry and writes a tail link
// if needed, or scans the whole limit if none is free. The search limit is
// min(data_block_count, TABLE_ENTRIES). The table RAM has one read port, so
// every walk or scan advances one entry per cycle. There is no clear pass:
// table entries must be written before they are read, directly or by a walk.
module fat_chain_allocator_unit #(
  parameter int TABLE_ENTRIES = 8192
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_operation,
  input  logic [fca_pkg::DATA_W-1:0] in_index,
  input  logic [fca_pkg::DATA_W-1:0] in_link_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [fca_pkg::DATA_W-1:0] out_result_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fca_pkg::CFG_W-1:0]  cfg_data_block_count
);

  import fca_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [DATA_W-1:0] TE = DATA_W'(TABLE_ENTRIES);

  logic [CFG_W-1:0]  cfg_r;
  logic [DATA_W-1:0] cfg_ext;
  logic [DATA_W-1:0] lim;

  logic              res_valid;
  logic              res_ready;
  fca_res_t          res;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [DATA_W-1:0] out_result_value_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data_block_count;
    end
  end

  assign cfg_ext = DATA_W'(cfg_r);
  assign lim     = (cfg_ext > TE) ? TE : cfg_ext;

  fca_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IW           (IW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_index     (in_index),
    .in_link_value(in_link_value),
    .lim          (lim),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  fca_table_ram #(
    .DEPTH(TABLE_ENTRIES),
    .AW   (IW),
    .DW   (DATA_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r       <= res.status;
      out_result_value_r <= res.value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_result_value_r;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fat_chain_allocator_unit. A shadow copy of the link
// table predicts status and value of every request. Results are checked in
// order while both channels idle at random and the block count is changed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import fca_pkg::*;

  localparam int TABLE_N   = 8192;
  localparam int FILL_N    = 160;
  localparam int CYCLE_CAP = 2000000;
  localparam int IDLE_PCT  = 18;
  localparam int DRAIN_CYC = 40;
  localparam int PRINT_CAP = 40;

  class fat_scoreboard;
    bit [DATA_W-1:0] links [TABLE_N];
    int unsigned     block_count;
    fca_res_t        awaited [$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     op_hits [8];
    int              last_alloc;
    bit [DATA_W-1:0] chain_starts [$];

    function new();
      block_count = CFG_RESET;
      last_alloc  = -1;
    endfunction

    function int unsigned search_span();
      return (block_count < TABLE_N) ? block_count : TABLE_N;
    endfunction

    function void note_request(logic [2:0] op, logic [DATA_W-1:0] idx,
                               logic [DATA_W-1:0] lnk);
      fca_res_t    r;
      int unsigned cur, nxt, span, i;
      r.status = ST_OK;
      r.value  = '0;
      span     = search_span();
      op_hits[op]++;
      case (op)
        OP_WRITE: begin
          if (idx < TABLE_N) links[idx] = lnk;
          else r.status = ST_RANGE;
        end
        OP_READ: begin
          if (idx < TABLE_N) r.value = links[idx];
          else r.status = ST_RANGE;
        end
        OP_FREE: begin
          cur = idx;
          while (cur != END_MARK) begin
            if (cur >= TABLE_N) begin
              r.status = ST_RANGE;
              break;
            end
            nxt = links[cur];
            if (nxt == FREE_MARK) break;
            links[cur] = FREE_MARK;
            r.value    = r.value + 1'b1;
            cur        = nxt;
          end
        end
        OP_ALLOC: begin
          if (idx != END_MARK && idx >= TABLE_N) begin
            r.status = ST_RANGE;
          end else begin
            for (i = 0; i < span; i++)
              if (links[i] == FREE_MARK) break;
            if (i >= span) begin
              r.status = ST_NO_FREE;
            end else begin
              links[i] = END_MARK;
              // a tail that is the new entry itself keeps the end mark
              if (idx != END_MARK && idx != i) links[idx] = DATA_W'(i);
              r.value    = DATA_W'(i);
              last_alloc = i;
              if (idx == END_MARK) chain_starts.push_back(DATA_W'(i));
              if (chain_starts.size() > 64) chain_starts.delete(0);
            end
          end
        end
        OP_COUNT: begin
          for (i = 0; i < span; i++)
            if (links[i] == FREE_MARK) r.value = r.value + 1'b1;
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [DATA_W-1:0] val);
      fca_res_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: result with no request pending: status %0d value %h",
                   $time, st, val);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (st !== want.status) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
      if (val !== want.value) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: value expected %h actual %h", $time, want.value, val);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_operation = '0;
  logic [DATA_W-1:0] in_index = '0;
  logic [DATA_W-1:0] in_link_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_result_value;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data_block_count = '0;

  fat_scoreboard board;
  bit            quiet_stretch = 1'b0;
  int unsigned   cycle_count = 0;
  int unsigned   settings_run = 0;

  fat_chain_allocator_unit #(.TABLE_ENTRIES(TABLE_N)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_index             (in_index),
    .in_link_value        (in_link_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_result_value     (out_result_value),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data_block_count (cfg_data_block_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_status, out_result_value);
    out_stall <= !quiet_stretch && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // valid stays high when the next request follows right after acceptance
  task automatic send_request(logic [2:0] op, logic [DATA_W-1:0] idx,
                              logic [DATA_W-1:0] lnk);
    while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_index      <= idx;
    in_link_value <= lnk;
    do @(posedge clk); while (in_stall);
    board.note_request(op, idx, lnk);
  endtask

  task automatic wait_drained();
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_block_count(logic [CFG_W-1:0] cnt);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid            <= 1'b1;
    cfg_data_block_count <= cnt;
    do @(posedge clk); while (!cfg_ready);
    board.block_count = cnt;
    cfg_valid <= 1'b0;
  endtask

  // stays inside the entries written at the start
  function automatic logic [DATA_W-1:0] near_index(int unsigned span);
    int unsigned top;
    top = (span + 8 < FILL_N) ? span + 8 : FILL_N - 1;
    return DATA_W'($urandom_range(top));
  endfunction

  // always past the table, end mark included
  function automatic logic [DATA_W-1:0] far_index();
    return DATA_W'($urandom_range(32'hFFFF, TABLE_N));
  endfunction

  // mostly chain building and freeing, with stray tails, raw writes and noise
  task automatic random_request(int unsigned span);
    int unsigned       pick, k;
    logic [2:0]        op;
    logic [DATA_W-1:0] idx, lnk;
    pick = $urandom_range(99);
    idx  = near_index(span);
    lnk  = far_index();
    if (pick < 35) begin
      op = OP_ALLOC;
      k  = $urandom_range(99);
      if (k < 50 && board.last_alloc >= 0) idx = DATA_W'(board.last_alloc);
      else if (k < 75) idx = END_MARK;
      else if (k >= 90) idx = DATA_W'($urandom);
    end else if (pick < 55) begin
      op = OP_FREE;
      k  = $urandom_range(99);
      if (k < 60 && board.chain_starts.size() != 0) begin
        k   = $urandom_range(board.chain_starts.size() - 1);
        idx = board.chain_starts[k];
        board.chain_starts.delete(k);
      end else if (k < 75) begin
        idx = END_MARK;
      end else if (k >= 90) begin
        idx = far_index();
      end
    end else if (pick < 70) begin
      op = OP_WRITE;
      k  = $urandom_range(99);
      if (k < 30) lnk = FREE_MARK;
      else if (k < 45) lnk = END_MARK;
      else if (k < 75) lnk = near_index(span);
      if ($urandom_range(9) == 0) idx = DATA_W'($urandom);
    end else if (pick < 82) begin
      op = OP_READ;
      if ($urandom_range(9) == 0) idx = far_index();
    end else if (pick < 94) begin
      // a scan past the written entries would read undefined ones
      op = (span > FILL_N) ? OP_READ : OP_COUNT;
    end else begin
      op  = 3'(OP_COUNT) + 3'($urandom_range(1, 3));
      idx = DATA_W'($urandom);
    end
    send_request(op, idx, lnk);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] cnt, int unsigned len, bit calm);
    int unsigned span;
    write_block_count(cnt);
    quiet_stretch <= calm;
    span = (cnt < TABLE_N) ? cnt : TABLE_N;
    settings_run++;
    repeat (len) random_request(span);
  endtask

  task automatic directed_requests();
    send_request(OP_COUNT, '0, '0);
    send_request(OP_ALLOC, END_MARK, '0);
    send_request(OP_ALLOC, 16'd0, '0);
    send_request(OP_ALLOC, 16'd1, '0);
    send_request(OP_READ, 16'd0, '0);
    send_request(OP_READ, 16'd2, '0);
    send_request(OP_WRITE, 16'(TABLE_N - 1), END_MARK);
    send_request(OP_WRITE, 16'(TABLE_N), 16'h1234);
    send_request(OP_READ, END_MARK, '0);
    send_request(OP_WRITE, END_MARK, END_MARK);
    send_request(OP_ALLOC, 16'(TABLE_N), '0);
    send_request(OP_ALLOC, END_MARK, '0);
    // tail is the entry the search will find
    send_request(OP_ALLOC, 16'd4, '0);
    send_request(OP_FREE, 16'd0, '0);
    send_request(OP_FREE, END_MARK, '0);
    send_request(OP_FREE, 16'd0, '0);
    // chain running into an out of range link
    send_request(OP_WRITE, 16'd10, 16'd11);
    send_request(OP_WRITE, 16'd11, 16'(TABLE_N + 808));
    send_request(OP_FREE, 16'd10, '0);
    // chain running into a free entry
    send_request(OP_WRITE, 16'd20, 16'd21);
    send_request(OP_FREE, 16'd20, '0);
    // tail already holds an end mark and gets relinked
    send_request(OP_ALLOC, 16'(TABLE_N - 1), '0);
    send_request(3'(OP_COUNT) + 3'd1, 16'hA5A5, 16'h5A5A);
    send_request(3'(OP_COUNT) + 3'd3, END_MARK, END_MARK);
    send_request(OP_COUNT, '0, '0);
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // the table has no clear pass, so the entries the run reads are written free first
    for (int e = 0; e < FILL_N; e++) send_request(OP_WRITE, DATA_W'(e), FREE_MARK);
    write_block_count(CFG_W'(FILL_N));
    directed_requests();
    run_phase(14'd20, 60, 1'b0);
    run_phase(14'd0, 20, 1'b0);
    run_phase(14'd1, 20, 1'b0);
    run_phase(14'd64, 100, 1'b1);
    run_phase(14'd16383, 25, 1'b0);
    run_phase(14'd8192, 15, 1'b0);
    run_phase(14'd120, 115, 1'b0);
    run_phase(14'd5, 40, 1'b0);
    in_valid      <= 1'b0;
    quiet_stretch <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    $display("Ran table fill, directed cases and %0d block count settings:", settings_run);
    $display("  %0d allocates, %0d chain frees, %0d counts; %0d results compared",
             board.op_hits[OP_ALLOC], board.op_hits[OP_FREE], board.op_hits[OP_COUNT],
             board.checked);
    if (board.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
